>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a condition implies another at the same edge outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/encc_pkg.sv
// Types and constants of the even-neighbor count unit.
package encc_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LEAD_W       = COL_W + 1;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int PIXEL_W      = 32;
    localparam int COUNT_W      = 4;
    localparam int NUM_NBRS     = 8;
    localparam int DATA_W       = ((COUNT_W + ROW_W + COL_W + 7) / 8) * 8;
    localparam int RESET_WIDTH  = 3;
    localparam int RESET_HEIGHT = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } nbr_mask_t;

    typedef struct packed {
        logic             parity_even;
        logic [COL_W-1:0] addr;
        logic             emit;
        nbr_mask_t        mask;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } step_t;

endpackage

>>> rtl/core/even_neighbor_count_3x3_unit.sv
// Top level of the even-neighbor count unit for raster frames.
//
// Input stream s_*: one beat per pixel (s_tuser = 0, s_tdata = value) or a
// drain tick (s_tuser = 1) after the frame's last pixel. Result stream m_*:
// count of even in-frame neighbors of one position with its row and column;
// m_tlast marks the frame's final result, after which the next frame starts.
// Pixels after the frame's last pixel and drains before it are taken and
// dropped. Config port cfg_*: index 0 = frame width, 1 = frame height; a
// write restarts the frame. Throughput: one beat per cycle while the queue
// has room and no pad step is pending. The result for position k comes out
// after pixel k+width+1 is taken, or after a drain at frame end. In a frame
// of no more than width pixels the first drain holds s_tready low while the
// window steps past the frame end.
// Reset: width and height 3, frame position zero, queue and outputs empty.
// A stalled receiver holds the result register; four queued steps absorb
// further beats before s_tready drops.
module even_neighbor_count_3x3_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [encc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [encc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [encc_pkg::PIXEL_W-1:0]   s_tdata,   // pixel_value
    input  logic                           s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [encc_pkg::DATA_W-1:0]    m_tdata,   // even_nbrs, out_row, out_col
    output logic                           m_tlast
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    encc_pkg::step_t push_step;
    encc_pkg::step_t pop_step;

    encc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_step    (push_step)
    );

    encc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_step (push_step),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_step  (pop_step)
    );

    encc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_step   (pop_step),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/encc_front.sv
// Front end: takes input beats, tracks frame position and issues window steps.
`include "assert_macros.svh"

module encc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [encc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [encc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [encc_pkg::PIXEL_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output encc_pkg::step_t                q_step
);

    logic [encc_pkg::COL_W-1:0]  wm1_reg, wm1_next;
    logic [encc_pkg::ROW_W-1:0]  hm1_reg, hm1_next;
    logic [encc_pkg::COL_W-1:0]  sp_col_reg, sp_col_next;
    logic [encc_pkg::ROW_W-1:0]  in_row_reg, in_row_next;
    logic                        in_done_reg, in_done_next;
    logic [encc_pkg::LEAD_W-1:0] lead_reg, lead_next;
    logic [encc_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [encc_pkg::COL_W-1:0]  out_col_reg, out_col_next;

    logic [encc_pkg::COL_W-1:0]  cfg_wm1;
    logic [encc_pkg::ROW_W-1:0]  cfg_hm1;
    logic [encc_pkg::LEAD_W-1:0] lead_target;
    logic                        lead_full;
    logic                        is_drain;
    logic                        pad_need;
    logic                        accept;
    logic                        take_pixel;
    logic                        take_drain;
    logic                        last_pos;
    logic                        restart;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_wm1 = '0;
        end else if (int'(cfg_data) > encc_pkg::MAX_WIDTH) begin
            cfg_wm1 = encc_pkg::COL_W'(encc_pkg::MAX_WIDTH - 1);
        end else begin
            cfg_wm1 = encc_pkg::COL_W'(cfg_data - encc_pkg::CFG_W'(1));
        end
        if (cfg_data == '0) begin
            cfg_hm1 = '0;
        end else if (int'(cfg_data) > encc_pkg::MAX_HEIGHT) begin
            cfg_hm1 = encc_pkg::ROW_W'(encc_pkg::MAX_HEIGHT - 1);
        end else begin
            cfg_hm1 = encc_pkg::ROW_W'(cfg_data - encc_pkg::CFG_W'(1));
        end
    end

    always_comb begin
        lead_target = encc_pkg::LEAD_W'(wm1_reg) + encc_pkg::LEAD_W'(2);
        lead_full   = (lead_reg == lead_target);
        is_drain    = (encc_pkg::cmd_t'(s_tuser) == encc_pkg::CMD_DRAIN);
        pad_need    = s_tvalid && is_drain && in_done_reg && !lead_full;
        s_tready    = !q_full && !pad_need;
        accept      = s_tvalid && s_tready;
        take_pixel  = accept && !is_drain && !in_done_reg;
        take_drain  = accept && is_drain && in_done_reg;
        q_push      = take_pixel || take_drain || (pad_need && !q_full);
        last_pos    = (out_row_reg == hm1_reg) && (out_col_reg == wm1_reg);

        q_step.parity_even    = take_pixel && !s_tdata[0];
        q_step.addr           = sp_col_reg;
        q_step.emit           = lead_full;
        q_step.mask.top_ok    = (out_row_reg != '0);
        q_step.mask.bot_ok    = (out_row_reg != hm1_reg);
        q_step.mask.left_ok   = (out_col_reg != '0);
        q_step.mask.right_ok  = (out_col_reg != wm1_reg);
        q_step.row            = out_row_reg;
        q_step.col            = out_col_reg;
        q_step.last           = last_pos;

        wm1_next     = wm1_reg;
        hm1_next     = hm1_reg;
        sp_col_next  = sp_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        lead_next    = lead_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        restart      = 1'b0;

        if (q_push) begin
            sp_col_next = (sp_col_reg == wm1_reg) ? '0 : sp_col_reg + 1'b1;
            if (!lead_full) begin
                lead_next = lead_reg + 1'b1;
            end
            if (take_pixel && (sp_col_reg == wm1_reg)) begin
                if (in_row_reg == hm1_reg) begin
                    in_done_next = 1'b1;
                end else begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end
            if (lead_full) begin
                if (out_col_reg == wm1_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
                restart = last_pos;
            end
        end

        if (cfg_valid) begin
            case (cfg_index)
                encc_pkg::REG_FRAME_WIDTH: begin
                    wm1_next = cfg_wm1;
                    restart  = 1'b1;
                end
                encc_pkg::REG_FRAME_HEIGHT: begin
                    hm1_next = cfg_hm1;
                    restart  = 1'b1;
                end
                default: ;
            endcase
        end

        if (restart) begin
            sp_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            lead_next    = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg     <= encc_pkg::COL_W'(encc_pkg::RESET_WIDTH - 1);
            hm1_reg     <= encc_pkg::ROW_W'(encc_pkg::RESET_HEIGHT - 1);
            sp_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            lead_reg    <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            wm1_reg     <= wm1_next;
            hm1_reg     <= hm1_next;
            sp_col_reg  <= sp_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            lead_reg    <= lead_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    `ASSERT_ALWAYS(a_lead_bound, lead_reg <= lead_target, "step lead beyond window span")
    `ASSERT_IMPLY(a_emit_in_frame, q_push && lead_full, out_row_reg <= hm1_reg, "result row past frame")

endmodule

>>> rtl/core/encc_queue.sv
// Short step queue between front end and window back end.
`include "assert_macros.svh"

module encc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  encc_pkg::step_t push_step,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output encc_pkg::step_t pop_step
);

    encc_pkg::step_t               entry_reg [encc_pkg::QUEUE_DEPTH];
    logic [encc_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [encc_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [encc_pkg::QPTR_W:0]     count_reg, count_next;

    always_comb begin
        full        = (count_reg == (encc_pkg::QPTR_W + 1)'(encc_pkg::QUEUE_DEPTH));
        valid       = (count_reg != '0);
        pop_step    = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(pop && !valid), "pop from empty queue")

endmodule

>>> rtl/core/encc_back.sv
// Back end: parity line buffers, 3x3 window and result register.
`include "assert_macros.svh"

module encc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  encc_pkg::step_t              q_step,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [encc_pkg::DATA_W-1:0]  m_tdata,
    output logic                         m_tlast
);

    logic                          lb1_mem [encc_pkg::MAX_WIDTH];
    logic                          lb2_mem [encc_pkg::MAX_WIDTH];
    logic                          lb1_q_reg;
    logic                          lb2_q_reg;

    logic                          a_valid_reg, a_valid_next;
    encc_pkg::step_t               a_step_reg;
    logic [2:0]                    win_l_reg;
    logic [2:0]                    win_c_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [encc_pkg::COUNT_W-1:0]  even_nbrs_reg;
    logic [encc_pkg::ROW_W-1:0]    out_row_reg;
    logic [encc_pkg::COL_W-1:0]    out_col_reg;
    logic                          frame_last_reg;

    logic                          m_room;
    logic                          adv_a;
    logic                          bypass;
    logic [2:0]                    new_col;
    logic [encc_pkg::NUM_NBRS-1:0] nbr_bits;
    logic [encc_pkg::COUNT_W-1:0]  count;

    always_comb begin
        m_room  = !m_tvalid_reg || m_tready;
        adv_a   = a_valid_reg && m_room;
        q_pop   = q_valid && (!a_valid_reg || adv_a);
        bypass  = adv_a && q_pop && (q_step.addr == a_step_reg.addr);
        new_col = {lb2_q_reg, lb1_q_reg, a_step_reg.parity_even};

        nbr_bits[0] = win_l_reg[2] && a_step_reg.mask.left_ok && a_step_reg.mask.top_ok;
        nbr_bits[1] = win_c_reg[2] && a_step_reg.mask.top_ok;
        nbr_bits[2] = new_col[2] && a_step_reg.mask.right_ok && a_step_reg.mask.top_ok;
        nbr_bits[3] = win_l_reg[1] && a_step_reg.mask.left_ok;
        nbr_bits[4] = new_col[1] && a_step_reg.mask.right_ok;
        nbr_bits[5] = win_l_reg[0] && a_step_reg.mask.left_ok && a_step_reg.mask.bot_ok;
        nbr_bits[6] = win_c_reg[0] && a_step_reg.mask.bot_ok;
        nbr_bits[7] = new_col[0] && a_step_reg.mask.right_ok && a_step_reg.mask.bot_ok;

        count = '0;
        for (int i = 0; i < encc_pkg::NUM_NBRS; i++) begin
            count = count + encc_pkg::COUNT_W'(nbr_bits[i]);
        end

        a_valid_next = a_valid_reg;
        if (q_pop) begin
            a_valid_next = 1'b1;
        end else if (adv_a) begin
            a_valid_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (adv_a && a_step_reg.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            lb1_mem[a_step_reg.addr] <= a_step_reg.parity_even;
            lb2_mem[a_step_reg.addr] <= lb1_q_reg;
        end
        if (q_pop) begin
            if (bypass) begin
                lb1_q_reg <= a_step_reg.parity_even;
                lb2_q_reg <= lb1_q_reg;
            end else begin
                lb1_q_reg <= lb1_mem[q_step.addr];
                lb2_q_reg <= lb2_mem[q_step.addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_step_reg <= q_step;
        end
        if (adv_a) begin
            win_l_reg <= win_c_reg;
            win_c_reg <= new_col;
        end
        if (adv_a && a_step_reg.emit) begin
            even_nbrs_reg  <= count;
            out_row_reg    <= a_step_reg.row;
            out_col_reg    <= a_step_reg.col;
            frame_last_reg <= a_step_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            a_valid_reg  <= a_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = encc_pkg::DATA_W'({out_col_reg, out_row_reg, even_nbrs_reg});
    assign m_tlast  = frame_last_reg;

    `ASSERT_IMPLY(a_count_range, m_tvalid_reg, even_nbrs_reg <= encc_pkg::COUNT_W'(encc_pkg::NUM_NBRS), "neighbor count above eight")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the even-neighbor count unit over streamed raster frames.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import encc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic               last;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COUNT_W-1:0] count;
    } nbr_count_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        cmd_t                 cmd;
        logic [PIXEL_W-1:0]   pix;
        logic                 fixed;
        nbr_count_t           res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIXEL_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 m_tlast;

    logic       beat_fixed;
    nbr_count_t beat_fixed_res;

    logic [CFG_W-1:0] width_reg = CFG_W'(RESET_WIDTH);
    logic [CFG_W-1:0] height_reg = CFG_W'(RESET_HEIGHT);
    bit               even_map [MAX_WIDTH*MAX_HEIGHT];
    int               pixels_in = 0;
    int               results_out = 0;
    nbr_count_t       expected_counts [$];

    int failures = 0;
    int beats_taken = 0;
    int results_checked = 0;
    int settings_seen = 0;
    int stream_beats = 0;
    int send_max = 10;
    int rcv_max = 10;
    bit paused_once = 0;

    even_neighbor_count_3x3_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void next_count(int w, int total, output nbr_count_t res);
        int h;
        int r;
        int c;
        int cnt;
        h = total / w;
        r = results_out / w;
        c = results_out % w;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < h &&
                    c + dc >= 0 && c + dc < w && even_map[(r + dr) * w + c + dc])
                    cnt++;
            end
        end
        res.count = COUNT_W'(cnt);
        res.row = ROW_W'(r);
        res.col = COL_W'(c);
        res.last = (results_out + 1 == total);
        results_out++;
        if (results_out >= total) begin
            pixels_in = 0;
            results_out = 0;
        end
    endfunction

    function automatic bit step_frame(cmd_t cmd, logic [PIXEL_W-1:0] pix,
                                      output nbr_count_t res);
        int w;
        int total;
        w = eff_dim(width_reg, MAX_WIDTH);
        total = w * eff_dim(height_reg, MAX_HEIGHT);
        res = '0;
        if (cmd == CMD_PIXEL) begin
            if (pixels_in >= total) return 0;
            even_map[pixels_in] = ~pix[0];
            pixels_in++;
            if (results_out < total && pixels_in > results_out + w + 1) begin
                next_count(w, total, res);
                return 1;
            end
            return 0;
        end
        if (pixels_in >= total && results_out < total) begin
            next_count(w, total, res);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : predict_blk
        nbr_count_t predicted;
        bit         got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = cfg_data;
                        pixels_in = 0;
                        results_out = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = cfg_data;
                        pixels_in = 0;
                        results_out = 0;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                got = step_frame(cmd_t'(s_tuser), s_tdata, predicted);
                if (beat_fixed)
                    expected_counts.push_back(beat_fixed_res);
                else if (got)
                    expected_counts.push_back(predicted);
                beats_taken++;
            end
        end
    end

    always @(posedge aclk) begin : check_blk
        nbr_count_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result beat: even_nbrs %0d row %0d col %0d last %0d",
                       m_tdata[COUNT_W-1:0], m_tdata[COUNT_W +: ROW_W],
                       m_tdata[COUNT_W+ROW_W +: COL_W], m_tlast);
                failures++;
            end else begin
                want = expected_counts.pop_front();
                results_checked++;
                if (m_tdata[COUNT_W-1:0] !== want.count) begin
                    $error("even_nbrs: expected %0d, actual %0d",
                           want.count, m_tdata[COUNT_W-1:0]);
                    failures++;
                end
                if (m_tdata[COUNT_W +: ROW_W] !== want.row) begin
                    $error("out_row: expected %0d, actual %0d",
                           want.row, m_tdata[COUNT_W +: ROW_W]);
                    failures++;
                end
                if (m_tdata[COUNT_W+ROW_W +: COL_W] !== want.col) begin
                    $error("out_col: expected %0d, actual %0d",
                           want.col, m_tdata[COUNT_W+ROW_W +: COL_W]);
                    failures++;
                end
                if (m_tlast !== want.last) begin
                    $error("frame_last: expected %0d, actual %0d", want.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial begin : receiver_blk
        int gap;
        int taken;
        taken = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            // hold off long once so the block backs up into its input
            gap = (taken == 40) ? 300 : $urandom_range(0, rcv_max);
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            if (taken % 32 == 0)
                rcv_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_beat(cmd_t cmd, logic [PIXEL_W-1:0] pix, logic fixed,
                             nbr_count_t res);
        int gap;
        gap = $urandom_range(0, send_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= pix;
        beat_fixed <= fixed;
        beat_fixed_res <= res;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge aclk);
    endtask

    task automatic settle();
        drain_results();
        repeat (eff_dim(width_reg, MAX_WIDTH) + 16) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_FRAME_WIDTH, wv);
            write_reg(REG_FRAME_HEIGHT, hv);
        end else begin
            write_reg(REG_FRAME_HEIGHT, hv);
            write_reg(REG_FRAME_WIDTH, wv);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
        settings_seen++;
    endtask

    task automatic send_frame(int w, int h, bit cut_short);
        int total;
        int stop_at;
        int drains;
        total = w * h;
        stop_at = cut_short ? $urandom_range(0, total - 1) : total;
        for (int p = 0; p < stop_at; p++) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(CMD_DRAIN, $urandom, 1'b0, '0);
            if (!paused_once && p == total / 2 && total > 2 * w + 4) begin
                drain_results();
                paused_once = 1;
            end
            send_beat(CMD_PIXEL, $urandom, 1'b0, '0);
            stream_beats++;
        end
        if (cut_short) return;
        drains = (total < w + 1) ? total : w + 1;
        for (int d = 0; d < drains; d++) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(CMD_PIXEL, $urandom, 1'b0, '0);
            send_beat(CMD_DRAIN, $urandom, 1'b0, '0);
            stream_beats++;
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(int common_hi, int rare_hi);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'($urandom_range(common_hi + 1, rare_hi));
        return CFG_W'($urandom_range(1, common_hi));
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        stim_row_t sr;
        sr = '0;
        sr.is_cfg = 1'b1;
        sr.idx = idx;
        sr.val = val;
        return sr;
    endfunction

    function automatic stim_row_t beat_row(cmd_t cmd, logic [PIXEL_W-1:0] pix, logic fixed,
                                           int cnt, int r, int c, logic last);
        stim_row_t sr;
        sr = '0;
        sr.cmd = cmd;
        sr.pix = pix;
        sr.fixed = fixed;
        sr.res.count = COUNT_W'(cnt);
        sr.res.row = ROW_W'(r);
        sr.res.col = COL_W'(c);
        sr.res.last = last;
        return sr;
    endfunction

    initial begin : stimulus_blk
        stim_row_t        directed_rows [$];
        logic             prev_cfg;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        int               w;
        int               h;
        int               nframes;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        beat_fixed = 1'b0;
        beat_fixed_res = '0;

        // 3x3 frame at reset size, all even, with dropped beats around it
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h0000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h8000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h7FFF_FFFE, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'hFFFF_FFFE, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h0000_0002, 1, 3, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'hAAAA_AAAA, 1, 5, 0, 1, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h5555_5554, 1, 3, 0, 2, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'hFFFF_FFFC, 1, 5, 1, 0, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h0000_0004, 1, 8, 1, 1, 0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'hFFFF_FFFF, 1, 5, 1, 2, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 1, 3, 2, 0, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 1, 5, 2, 1, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 1, 3, 2, 2, 1));
        // zero sizes count as one: 1x1 frame
        directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 11'd0));
        directed_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd0));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h0000_0001, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 1, 0, 0, 0, 1));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_SPARE_2, 11'h7FF));
        directed_rows.push_back(cfg_row(REG_SPARE_3, 11'h000));
        directed_rows.push_back(beat_row(CMD_PIXEL, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(CMD_DRAIN, 32'h0000_0000, 1, 0, 0, 0, 1));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        prev_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                if (!prev_cfg) settle();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_beat(directed_rows[i].cmd, directed_rows[i].pix,
                          directed_rows[i].fixed, directed_rows[i].res);
            end
            prev_cfg = directed_rows[i].is_cfg;
        end

        // saturating width: widest rows, stopped once the first results are out
        set_frame(11'd2047, 11'd2);
        for (int p = 0; p < MAX_WIDTH + 64; p++) begin
            send_beat(CMD_PIXEL, $urandom, 1'b0, '0);
            stream_beats++;
        end

        while (stream_beats < 1400) begin
            wv = pick_dim(12, 40);
            hv = pick_dim(6, 12);
            set_frame(wv, hv);
            w = eff_dim(wv, MAX_WIDTH);
            h = eff_dim(hv, MAX_HEIGHT);
            send_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
                send_frame(w, h, f == nframes - 1 && w * h > 1 && $urandom_range(0, 7) == 0);
        end

        drain_results();
        repeat (64) @(negedge aclk);

        $display("Run covered %0d input beats over %0d frame settings plus directed frames,",
                 beats_taken, settings_seen);
        $display("with %0d results checked and %0d field mismatches.",
                 results_checked, failures);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
